@@ rtl/rmq_pkg.sv @@
package rmq_pkg;

    // Field and datapath widths
    localparam int DW    = 32;  // Q2.30 field width
    localparam int RAD_W = 33;  // clamped radicand, unsigned
    localparam int DIF_W = 33;  // off-diagonal sum or difference, signed
    localparam int LANES = 3;   // off-diagonal quotients per item
    localparam int QB    = 32;  // quotient bits before saturation
    localparam int NMAT  = 9;   // matrix entries

    // Branch of the trace method, named after the component taken from the root
    typedef enum logic [1:0] {
        SEL_W = 2'd0,
        SEL_X = 2'd1,
        SEL_Y = 2'd2,
        SEL_Z = 2'd3
    } t_sel;

    // Matrix entries, index r*3+c
    typedef logic [NMAT-1:0][DW-1:0] t_mat;

    // Branch and numerators, ordered w, x, y, z with the diagonal one skipped
    typedef struct packed {
        t_sel                         sel;
        logic [LANES-1:0][DIF_W-1:0]  d;
    } t_front;

    // Branch and diagonal component traveling beside the dividers
    typedef struct packed {
        t_sel          sel;
        logic [DW-1:0] diag;
    } t_dside;

endpackage

@@ rtl/rmq_if.sv @@
// Matrix channel
interface rmq_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   m00;
    logic signed [31:0]   m01;
    logic signed [31:0]   m02;
    logic signed [31:0]   m10;
    logic signed [31:0]   m11;
    logic signed [31:0]   m12;
    logic signed [31:0]   m20;
    logic signed [31:0]   m21;
    logic signed [31:0]   m22;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

// Quaternion channel
interface rmq_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   qw;
    logic signed [31:0]   qx;
    logic signed [31:0]   qy;
    logic signed [31:0]   qz;

    modport source (output valid, qw, qx, qy, qz, input ready);
    modport sink   (input valid, qw, qx, qy, qz, output ready);
endinterface

@@ rtl/rotation_matrix_to_quaternion_top.sv @@
// Channel   Dir  Beat payload                         Handshake
// i_in      in   m00 m01 m02 m10 m11 m12 m20 m21 m22  valid/ready
// o_out     out  qw qx qy qz                          valid/ready
//
// One beat enters per cycle while o_out is not stalled. Stages in order: one
// select stage, one root bit per stage, one prepare stage, one quotient bit per
// stage for three lanes at once, one output register.
// Reset (i_rst_n low, synchronous) clears all stage valid bits.
// A stall on o_out freezes every stage; nothing is dropped or repeated.
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rmq_in_if.sink       i_in,
    rmq_out_if.source    o_out
);
    import rmq_pkg::*;

    localparam int SQW = (RAD_W + FRAC_BITS + 1) / 2;

    logic                         w_en;
    t_mat                         w_mat;
    logic                         w_fv;
    logic [RAD_W-1:0]             w_rad;
    t_front                       w_fside;
    logic                         w_sv;
    logic [SQW-1:0]               w_root;
    t_front                       w_sside;
    logic                         w_dv;
    logic [LANES-1:0][QB-1:0]     w_q;
    logic [LANES-1:0]             w_ovf;
    logic [LANES-1:0]             w_neg;
    t_dside                       w_dside;
    logic [DW-1:0]                w_v [LANES];
    logic                         r_out_vld;
    logic [DW-1:0]                r_qw, r_qx, r_qy, r_qz;
    logic [DW-1:0]                n_qw, n_qx, n_qy, n_qz;

    // Whole pipeline advances unless the output beat is held
    assign w_en       = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    assign w_mat[0] = i_in.m00;
    assign w_mat[1] = i_in.m01;
    assign w_mat[2] = i_in.m02;
    assign w_mat[3] = i_in.m10;
    assign w_mat[4] = i_in.m11;
    assign w_mat[5] = i_in.m12;
    assign w_mat[6] = i_in.m20;
    assign w_mat[7] = i_in.m21;
    assign w_mat[8] = i_in.m22;

    rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_mat   (w_mat),
        .o_vld   (w_fv),
        .o_rad   (w_rad),
        .o_side  (w_fside)
    );

    rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fv),
        .i_rad   (w_rad),
        .i_side  (w_fside),
        .o_vld   (w_sv),
        .o_root  (w_root),
        .o_side  (w_sside)
    );

    rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sv),
        .i_root  (w_root),
        .i_side  (w_sside),
        .o_vld   (w_dv),
        .o_q     (w_q),
        .o_ovf   (w_ovf),
        .o_neg   (w_neg),
        .o_side  (w_dside)
    );

    // Sign and saturation per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (w_ovf[l] || w_q[l][QB-1]) begin
                w_v[l] = w_neg[l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else begin
                w_v[l] = w_neg[l] ? DW'(-w_q[l]) : DW'(w_q[l]);
            end
        end
    end

    // Put the diagonal component back in its slot
    always_comb begin
        case (w_dside.sel)
            SEL_W: begin
                n_qw = w_dside.diag; n_qx = w_v[0]; n_qy = w_v[1]; n_qz = w_v[2];
            end
            SEL_X: begin
                n_qw = w_v[0]; n_qx = w_dside.diag; n_qy = w_v[1]; n_qz = w_v[2];
            end
            SEL_Y: begin
                n_qw = w_v[0]; n_qx = w_v[1]; n_qy = w_dside.diag; n_qz = w_v[2];
            end
            SEL_Z: begin
                n_qw = w_v[0]; n_qx = w_v[1]; n_qy = w_v[2]; n_qz = w_dside.diag;
            end
            default: begin
                n_qw = w_v[0]; n_qx = w_v[1]; n_qy = w_v[2]; n_qz = w_dside.diag;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qw <= n_qw;
            r_qx <= n_qx;
            r_qy <= n_qy;
            r_qz <= n_qz;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.qw    = r_qw;
    assign o_out.qx    = r_qx;
    assign o_out.qy    = r_qy;
    assign o_out.qz    = r_qz;

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // The component taken from the root is always at least one LSB
    a_diag_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($signed(r_qw) > 0 || $signed(r_qx) > 0 ||
                       $signed(r_qy) > 0 || $signed(r_qz) > 0))
        else $error("no positive component in result");

    // A held output freezes the inner stages too
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_dv) && $stable(w_dside))
        else $error("pipeline moved during stall");

endmodule

@@ rtl/rmq_front.sv @@
module rmq_front #(
    parameter int FRAC_BITS = 30
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  rmq_pkg::t_mat              i_mat,
    output logic                       o_vld,
    output logic [rmq_pkg::RAD_W-1:0]  o_rad,
    output rmq_pkg::t_front            o_side
);
    import rmq_pkg::*;

    localparam int AW = 35;  // room for one plus three entry differences

    logic signed [AW-1:0]    w_a [NMAT];
    logic signed [AW-1:0]    w_tr;
    logic signed [AW-1:0]    w_one;
    logic signed [AW-1:0]    w_rad;
    logic signed [DIF_W-1:0] w_da, w_db, w_dc, w_sxy, w_sxz, w_syz;
    logic                    r_vld;
    logic [RAD_W-1:0]        r_rad;
    t_front                  r_side;
    t_front                  n_side;
    logic [RAD_W-1:0]        n_rad;

    // Sign-extend the entries
    always_comb begin
        for (int i = 0; i < NMAT; i++) begin
            w_a[i] = AW'($signed(i_mat[i]));
        end
    end

    assign w_tr  = w_a[0] + w_a[4] + w_a[8];
    assign w_one = AW'(1) <<< FRAC_BITS;

    // Off-diagonal sums and differences
    assign w_da  = DIF_W'(w_a[7] - w_a[5]);
    assign w_db  = DIF_W'(w_a[2] - w_a[6]);
    assign w_dc  = DIF_W'(w_a[3] - w_a[1]);
    assign w_sxy = DIF_W'(w_a[1] + w_a[3]);
    assign w_sxz = DIF_W'(w_a[2] + w_a[6]);
    assign w_syz = DIF_W'(w_a[5] + w_a[7]);

    // Branch choice, ties fall to the later branch
    always_comb begin
        if (w_tr > 0) begin
            n_side.sel = SEL_W;
            w_rad      = w_tr + w_one;
            n_side.d   = {w_dc, w_db, w_da};
        end else if (w_a[0] > w_a[4] && w_a[0] > w_a[8]) begin
            n_side.sel = SEL_X;
            w_rad      = w_one + w_a[0] - w_a[4] - w_a[8];
            n_side.d   = {w_sxz, w_sxy, w_da};
        end else if (w_a[4] > w_a[8]) begin
            n_side.sel = SEL_Y;
            w_rad      = w_one + w_a[4] - w_a[0] - w_a[8];
            n_side.d   = {w_syz, w_sxy, w_db};
        end else begin
            n_side.sel = SEL_Z;
            w_rad      = w_one + w_a[8] - w_a[0] - w_a[4];
            n_side.d   = {w_syz, w_sxz, w_dc};
        end
    end

    // Clamp so the root never comes out zero
    assign n_rad = (w_rad < AW'(1)) ? RAD_W'(1) : w_rad[RAD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= n_rad;
            r_side <= n_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_side = r_side;

endmodule

@@ rtl/rmq_sqrt.sv @@
module rmq_sqrt #(
    parameter int FRAC_BITS = 30
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_vld,
    input  logic [rmq_pkg::RAD_W-1:0]                       i_rad,
    input  rmq_pkg::t_front                                 i_side,
    output logic                                            o_vld,
    output logic [(rmq_pkg::RAD_W+FRAC_BITS+1)/2-1:0]       o_root,
    output rmq_pkg::t_front                                 o_side
);
    import rmq_pkg::*;

    localparam int SQW = (RAD_W + FRAC_BITS + 1) / 2;  // root bits, one per stage
    localparam int NPW = 2 * SQW;                        // padded radicand
    localparam int RMW = SQW + 2;                        // partial remainder

    logic             r_vld  [SQW];
    logic [NPW-1:0]   r_n    [SQW];
    logic [RMW-1:0]   r_rem  [SQW];
    logic [SQW-1:0]   r_q    [SQW];
    t_front           r_side [SQW];

    logic             w_pvld  [SQW];
    logic [NPW-1:0]   w_pn    [SQW];
    logic [RMW-1:0]   w_prem  [SQW];
    logic [SQW-1:0]   w_pq    [SQW];
    t_front           w_pside [SQW];

    // One root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < SQW; k++) begin : g_stage
        logic [RMW-1:0] w_rs;
        logic [RMW-1:0] w_t;
        logic [RMW-1:0] n_rem;
        logic [SQW-1:0] n_q;

        if (k == 0) begin : g_first
            assign w_pvld[k]  = i_vld;
            assign w_pn[k]    = NPW'({i_rad, {FRAC_BITS{1'b0}}});
            assign w_prem[k]  = '0;
            assign w_pq[k]    = '0;
            assign w_pside[k] = i_side;
        end else begin : g_next
            assign w_pvld[k]  = r_vld[k-1];
            assign w_pn[k]    = r_n[k-1];
            assign w_prem[k]  = r_rem[k-1];
            assign w_pq[k]    = r_q[k-1];
            assign w_pside[k] = r_side[k-1];
        end

        always_comb begin
            w_rs = {w_prem[k][RMW-3:0], w_pn[k][NPW-1-2*k -: 2]};
            w_t  = {w_pq[k], 2'b01};
            if (w_rs >= w_t) begin
                n_rem = w_rs - w_t;
                n_q   = {w_pq[k][SQW-2:0], 1'b1};
            end else begin
                n_rem = w_rs;
                n_q   = {w_pq[k][SQW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_pvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]    <= w_pn[k];
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_side[k] <= w_pside[k];
            end
        end
    end

    assign o_vld  = r_vld[SQW-1];
    assign o_root = r_q[SQW-1];
    assign o_side = r_side[SQW-1];

endmodule

@@ rtl/rmq_div.sv @@
module rmq_div #(
    parameter int FRAC_BITS = 30
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  logic                                               i_en,
    input  logic                                               i_vld,
    input  logic [(rmq_pkg::RAD_W+FRAC_BITS+1)/2-1:0]          i_root,
    input  rmq_pkg::t_front                                    i_side,
    output logic                                               o_vld,
    output logic [rmq_pkg::LANES-1:0][rmq_pkg::QB-1:0]         o_q,
    output logic [rmq_pkg::LANES-1:0]                          o_ovf,
    output logic [rmq_pkg::LANES-1:0]                          o_neg,
    output rmq_pkg::t_dside                                    o_side
);
    import rmq_pkg::*;

    localparam int SQW  = (RAD_W + FRAC_BITS + 1) / 2;
    localparam int DENW = SQW + 1;                 // divisor 2*root
    localparam int NDW  = RAD_W + FRAC_BITS;       // |d| * 2^F + root
    localparam int DRW  = SQW + 2;                 // partial remainder
    localparam int CW   = (NDW > DENW + QB) ? NDW : DENW + QB;

    // Prepare stage
    logic              r_pv;
    logic [NDW-1:0]    r_pn   [LANES];
    logic              r_pneg [LANES];
    logic [DENW-1:0]   r_pden;
    t_dside            r_pside;
    logic [NDW-1:0]    n_pn   [LANES];
    logic              n_pneg [LANES];
    logic [DIF_W-1:0]  w_mag  [LANES];
    logic [SQW:0]      w_dsum;
    logic [SQW-1:0]    w_dhalf;
    t_dside            n_pside;

    // Magnitudes and rounded numerators
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_pneg[l] = i_side.d[l][DIF_W-1];
            w_mag[l]  = n_pneg[l] ? (~i_side.d[l] + 1'b1) : i_side.d[l];
            n_pn[l]   = NDW'({w_mag[l], {FRAC_BITS{1'b0}}}) + NDW'(i_root);
        end
    end

    // Diagonal component, root/2 rounded half up, saturated
    always_comb begin
        w_dsum        = {1'b0, i_root} + 1'b1;
        w_dhalf       = w_dsum[SQW:1];
        n_pside.sel   = i_side.sel;
        if (64'(w_dhalf) > 64'h7FFF_FFFF) begin
            n_pside.diag = 32'h7FFF_FFFF;
        end else begin
            n_pside.diag = DW'(w_dhalf);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pn    <= n_pn;
            r_pneg  <= n_pneg;
            r_pden  <= {i_root, 1'b0};
            r_pside <= n_pside;
        end
    end

    // Quotient stages, one bit per stage for all lanes
    logic              r_vld  [QB];
    logic [DENW-1:0]   r_den  [QB];
    t_dside            r_side [QB];
    logic [QB-1:0]     r_lo   [QB][LANES];
    logic [DRW-1:0]    r_rem  [QB][LANES];
    logic [QB-1:0]     r_q    [QB][LANES];
    logic              r_ovf  [QB][LANES];
    logic              r_neg  [QB][LANES];

    logic              w_pvld  [QB];
    logic [DENW-1:0]   w_pden  [QB];
    t_dside            w_pside [QB];
    logic [QB-1:0]     w_plo   [QB][LANES];
    logic [DRW-1:0]    w_prem  [QB][LANES];
    logic [QB-1:0]     w_pq    [QB][LANES];
    logic              w_povf  [QB][LANES];
    logic              w_pneg  [QB][LANES];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        if (k == 0) begin : g_first
            assign w_pvld[k]  = r_pv;
            assign w_pden[k]  = r_pden;
            assign w_pside[k] = r_pside;
        end else begin : g_next
            assign w_pvld[k]  = r_vld[k-1];
            assign w_pden[k]  = r_den[k-1];
            assign w_pside[k] = r_side[k-1];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [DRW-1:0] w_rs;
            logic [DRW-1:0] n_rem;
            logic [QB-1:0]  n_q;

            if (k == 0) begin : g_first
                assign w_plo[k][l]  = r_pn[l][QB-1:0];
                assign w_prem[k][l] = DRW'(r_pn[l][NDW-1:QB]);
                assign w_pq[k][l]   = '0;
                // quotient of 2^32 or more saturates
                assign w_povf[k][l] = CW'(r_pn[l]) >= CW'({r_pden, {QB{1'b0}}});
                assign w_pneg[k][l] = r_pneg[l];
            end else begin : g_next
                assign w_plo[k][l]  = r_lo[k-1][l];
                assign w_prem[k][l] = r_rem[k-1][l];
                assign w_pq[k][l]   = r_q[k-1][l];
                assign w_povf[k][l] = r_ovf[k-1][l];
                assign w_pneg[k][l] = r_neg[k-1][l];
            end

            always_comb begin
                w_rs = {w_prem[k][l][DRW-2:0], w_plo[k][l][QB-1-k]};
                if (w_rs >= DRW'(w_pden[k])) begin
                    n_rem = w_rs - DRW'(w_pden[k]);
                    n_q   = {w_pq[k][l][QB-2:0], 1'b1};
                end else begin
                    n_rem = w_rs;
                    n_q   = {w_pq[k][l][QB-2:0], 1'b0};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_lo[k][l]  <= w_plo[k][l];
                    r_rem[k][l] <= n_rem;
                    r_q[k][l]   <= n_q;
                    r_ovf[k][l] <= w_povf[k][l];
                    r_neg[k][l] <= w_pneg[k][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_pvld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= w_pden[k];
                r_side[k] <= w_pside[k];
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_q[l]   = r_q[QB-1][l];
            o_ovf[l] = r_ovf[QB-1][l];
            o_neg[l] = r_neg[QB-1][l];
        end
    end

    assign o_vld  = r_vld[QB-1];
    assign o_side = r_side[QB-1];

endmodule
